// ===== hw/rtl/etfp_pkg.sv =====
// ----------------------------------------------------------------------------
// etfp_pkg: shared types and arithmetic helpers of the escape-time pixel block
// Payload structs, register indexes and the Q6.26 saturation helpers.
// ----------------------------------------------------------------------------
package etfp_pkg;

    localparam int FRAC_BITS = 26;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_ZOOM_FACTOR      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_REAL      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_IMAG      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEED_REAL        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEED_IMAG        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_JULIA_MODE       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ITERATION_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_ESCAPE_THRESHOLD = 3'd7;

    localparam logic signed [40:0] MAP_BIAS = 41'sd134217728;

    typedef struct packed {
        logic [9:0] pixel_col;
        logic [9:0] pixel_row;
    } t_pixel_in;

    typedef struct packed {
        logic [15:0] iteration_count;
        logic        escaped;
    } t_pixel_out;

    // Saturates a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat_wide(input logic signed [40:0] v);
        if (v[40:31] != {10{v[40]}}) begin
            return v[40] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end
        return v[31:0];
    endfunction

    // Floor-shifts a product right by 26, or by 25 when doubled, and saturates.
    function automatic logic signed [31:0] prod_to_q(input logic signed [65:0] p,
                                                    input logic dbl);
        logic signed [40:0] s;
        s = dbl ? $signed(p[65:25]) : $signed({p[65], p[65:26]});
        return sat_wide(s);
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return sat_wide(41'(a) + 41'(b));
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return sat_wide(41'(a) - 41'(b));
    endfunction

endpackage

// ===== hw/rtl/etfp_map_div.sv =====
// ----------------------------------------------------------------------------
// etfp_map_div: coordinate scaling unit
// Divides a pixel index shifted up by 28 bits by the image size through one
// multiplication by a rounded-up reciprocal, exact for every 10-bit index.
// ----------------------------------------------------------------------------
module etfp_map_div #(
    parameter int IMAGE_SIZE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [9:0]  i_value,
    output logic        o_done,
    output logic [37:0] o_quot
);

    localparam int SHIFT = 10 + $clog2(IMAGE_SIZE);
    localparam int PW = SHIFT + 38;
    localparam longint unsigned RECIP_WIDE =
        ((64'd1 << (28 + SHIFT)) + 64'(IMAGE_SIZE) - 64'd1) / 64'(IMAGE_SIZE);
    localparam logic [39:0] RECIP = 40'(RECIP_WIDE);

    logic [PW-1:0] r_prod;
    logic          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PW'(i_value) * PW'(RECIP);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_prod[PW-1:SHIFT];

endmodule

// ===== hw/rtl/etfp_mul.sv =====
// ----------------------------------------------------------------------------
// etfp_mul: shared signed multiplier
// A 33 by 33 bit signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module etfp_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_prod
);

    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/escape_time_fractal_pixel.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel: Mandelbrot and Julia escape-time evaluator
// Maps a pixel to the complex plane and iterates z = z*z + c in Q6.26 until
// the squared magnitude passes the threshold or the step limit is reached.
//
// A pixel beat on the input channel carries a column and a row. One result
// beat follows with the step count and an escaped flag. Registers are written
// through the plain write port; the user must write them only while the block
// is idle, which the block itself does not enforce. A zero limit answers with
// a zero count and no escape, running no step. The coordinate scaling result
// is registered, and the single shared multiplier is used three times a step.
// One pixel is in work at a time; the input is stalled from acceptance until
// the result is loaded into the output register, which holds its beat while
// the receiver stalls, and a finished result waits in the core for as long as
// that register is held.
// Reset is synchronous and restores the default register values.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel #(
    parameter int IMAGE_SIZE = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  etfp_pkg::t_pixel_in                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output etfp_pkg::t_pixel_out                o_out_data,
    input  logic                                i_cfg_we,
    input  logic [etfp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [etfp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam logic [24:0] COUNT_CAP = (25'd1 << COUNT_BITS) - 25'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_MAPX, S_MAPY, S_ZY, S_SQX, S_SQY, S_TEST, S_XY, S_UPD, S_DONE
    } t_state;

    logic [30:0]        r_zoom;
    logic signed [31:0] r_off_re;
    logic signed [31:0] r_off_im;
    logic signed [31:0] r_seed_re;
    logic signed [31:0] r_seed_im;
    logic               r_julia;
    logic [15:0]        r_lim_cfg;
    logic [30:0]        r_thresh;

    t_state               r_state;
    logic [15:0]          r_limit;
    logic [15:0]          r_iter;
    logic                 r_first;
    logic signed [31:0]   r_zx;
    logic signed [31:0]   r_zy;
    logic signed [31:0]   r_cx;
    logic signed [31:0]   r_cy;
    logic signed [31:0]   r_xx;
    logic signed [31:0]   r_yy;
    etfp_pkg::t_pixel_out r_result;
    etfp_pkg::t_pixel_out r_out;
    logic                 r_out_valid;

    logic               accept;
    logic               div_start;
    logic               done_x;
    logic               done_y;
    logic [37:0]        quot_x;
    logic [37:0]        quot_y;
    logic signed [31:0] map_x;
    logic signed [31:0] map_y;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;
    logic signed [31:0] prod_q26;
    logic signed [31:0] zy_init;
    logic signed [32:0] mag;
    logic [15:0]        eff_limit;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign div_start = accept && (eff_limit != 16'd0);
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom    <= 31'd67108864;
            r_off_re  <= '0;
            r_off_im  <= '0;
            r_seed_re <= '0;
            r_seed_im <= '0;
            r_julia   <= 1'b0;
            r_lim_cfg <= 16'd42;
            r_thresh  <= 31'd268435456;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                etfp_pkg::REG_ZOOM_FACTOR:      r_zoom    <= i_cfg_data[30:0];
                etfp_pkg::REG_OFFSET_REAL:      r_off_re  <= $signed(i_cfg_data);
                etfp_pkg::REG_OFFSET_IMAG:      r_off_im  <= $signed(i_cfg_data);
                etfp_pkg::REG_SEED_REAL:        r_seed_re <= $signed(i_cfg_data);
                etfp_pkg::REG_SEED_IMAG:        r_seed_im <= $signed(i_cfg_data);
                etfp_pkg::REG_JULIA_MODE:       r_julia   <= i_cfg_data[0];
                etfp_pkg::REG_ITERATION_LIMIT:  r_lim_cfg <= i_cfg_data[15:0];
                etfp_pkg::REG_ESCAPE_THRESHOLD: r_thresh  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    etfp_map_div #(.IMAGE_SIZE(IMAGE_SIZE)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_value (i_in_data.pixel_col),
        .o_done  (done_x),
        .o_quot  (quot_x)
    );

    etfp_map_div #(.IMAGE_SIZE(IMAGE_SIZE)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_value (i_in_data.pixel_row),
        .o_done  (done_y),
        .o_quot  (quot_y)
    );

    etfp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        eff_limit = ({9'b0, r_lim_cfg} > COUNT_CAP) ? COUNT_CAP[15:0] : r_lim_cfg;
        map_x     = etfp_pkg::sat_wide($signed({3'b0, quot_x}) - etfp_pkg::MAP_BIAS);
        map_y     = etfp_pkg::sat_wide($signed({3'b0, quot_y}) - etfp_pkg::MAP_BIAS);
        prod_q26  = etfp_pkg::prod_to_q(prod, 1'b0);
        zy_init   = etfp_pkg::sat_add(prod_q26, r_off_im);
        mag       = 33'(r_xx) + 33'(prod_q26);
        mul_a     = 33'(r_zx);
        mul_b     = 33'(r_zx);
        unique case (r_state)
            S_MAPX: begin
                mul_a = 33'(map_x);
                mul_b = $signed({2'b0, r_zoom});
            end
            S_MAPY: begin
                mul_a = 33'(map_y);
                mul_b = $signed({2'b0, r_zoom});
            end
            S_SQY: begin
                mul_a = 33'(r_zy);
                mul_b = 33'(r_zy);
            end
            S_XY: begin
                mul_a = 33'(r_zx);
                mul_b = 33'(r_zy);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_first     <= 1'b1;
            r_iter      <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_limit <= eff_limit;
                        r_iter  <= '0;
                        r_first <= 1'b1;
                        if (eff_limit == 16'd0) begin
                            r_result <= '{iteration_count: 16'd0, escaped: 1'b0};
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (done_x && done_y) begin
                        r_state <= S_MAPX;
                    end
                end
                S_MAPX: r_state <= S_MAPY;
                S_MAPY: begin
                    r_zx    <= etfp_pkg::sat_add(prod_q26, r_off_re);
                    r_state <= S_ZY;
                end
                S_ZY: begin
                    r_zy    <= zy_init;
                    r_cx    <= r_julia ? r_seed_re : r_zx;
                    r_cy    <= r_julia ? r_seed_im : zy_init;
                    r_state <= S_SQX;
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: begin
                    r_xx    <= prod_q26;
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    r_yy <= prod_q26;
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_state <= S_XY;
                    end else if (mag > $signed({2'b0, r_thresh})) begin
                        r_result <= '{iteration_count: r_iter, escaped: 1'b1};
                        r_state  <= S_DONE;
                    end else if (r_iter + 16'd1 == r_limit) begin
                        r_result <= '{iteration_count: r_limit, escaped: 1'b0};
                        r_state  <= S_DONE;
                    end else begin
                        r_iter  <= r_iter + 16'd1;
                        r_state <= S_XY;
                    end
                end
                S_XY: r_state <= S_UPD;
                S_UPD: begin
                    r_zx    <= etfp_pkg::sat_add(etfp_pkg::sat_sub(r_xx, r_yy), r_cx);
                    r_zy    <= etfp_pkg::sat_add(etfp_pkg::prod_to_q(prod, 1'b1), r_cy);
                    r_state <= S_SQX;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_result;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
